// ===== rtl/rmjsl_pkg.sv =====
// Shared types and constants for the ramped multi-joint slew limiter.
// Used by rmjsl_speed, rmjsl_lane and ramped_multi_joint_slew_limiter.
package rmjsl_pkg;

   // default joint count
   localparam int JOINTS_DEF = 7;

   // field widths
   localparam int POS_W   = 24;
   localparam int DT_W    = 16;
   localparam int SPD_W   = 32;
   localparam int PROD_W  = SPD_W + DT_W;
   localparam int FRAC_W  = 16;
   localparam int OP_W    = 2;
   localparam int CSR_IDX_W = 2;

   // op codes carried in tuser
   localparam logic [OP_W-1:0] OP_START = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPEED = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_RATE = 2'd1;

   // speed unit stage enables
   typedef struct packed {
      logic ramp_en;   // latch ramp_rate*dt and below-ceiling flag
      logic clip_en;   // add ramp, clip, update speed
      logic step_en;   // latch speed*dt
   } spd_ctl_type;

   // per-lane controls
   typedef struct packed {
      logic load_tgt;  // write target register
      logic dev_en;    // latch deviation and magnitude
   } lane_ctl_type;

endpackage

// ===== rtl/rmjsl_speed.sv =====
// Shared speed ramp: holds the current speed and forms the step product.
// Depends on rmjsl_pkg.
module rmjsl_speed (
   input  logic                              clock,
   input  logic                              reset,
   input  rmjsl_pkg::spd_ctl_type            ctl,
   input  logic [rmjsl_pkg::SPD_W-1:0]       max_speed,
   input  logic [rmjsl_pkg::SPD_W-1:0]       ramp_rate,
   input  logic [rmjsl_pkg::DT_W-1:0]        dt_us,
   output logic [rmjsl_pkg::PROD_W-1:0]      prod
);

   logic [rmjsl_pkg::SPD_W-1:0]  speed_ff, speed_in;
   logic [rmjsl_pkg::PROD_W-1:0] ramp_ff;
   logic                         below_ff;
   logic [rmjsl_pkg::PROD_W-1:0] prod_ff;
   logic [rmjsl_pkg::PROD_W:0]   sum;

   // ramp added only while below the ceiling, then clipped
   always_comb begin
      sum = {{(rmjsl_pkg::DT_W+1){1'b0}}, speed_ff}
          + (below_ff ? {1'b0, ramp_ff} : '0);
      if (sum > {{(rmjsl_pkg::DT_W+1){1'b0}}, max_speed}) begin
         speed_in = max_speed;
      end else begin
         speed_in = sum[rmjsl_pkg::SPD_W-1:0];
      end
   end

   // speed state
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= '0;
      end else if (ctl.clip_en) begin
         speed_ff <= speed_in;
      end
   end

   // product registers
   always_ff @(posedge clock) begin
      if (ctl.ramp_en) begin
         ramp_ff  <= {{rmjsl_pkg::DT_W{1'b0}}, ramp_rate}
                   * {{rmjsl_pkg::SPD_W{1'b0}}, dt_us};
         below_ff <= speed_ff < max_speed;
      end
      if (ctl.step_en) begin
         prod_ff <= {{rmjsl_pkg::DT_W{1'b0}}, speed_ff}
                  * {{rmjsl_pkg::SPD_W{1'b0}}, dt_us};
      end
   end

   assign prod = prod_ff;

endmodule

// ===== rtl/rmjsl_lane.sv =====
// One joint lane: target register, deviation, step toward target, saturation.
// Depends on rmjsl_pkg.
module rmjsl_lane (
   input  logic                               clock,
   input  logic                               reset,
   input  rmjsl_pkg::lane_ctl_type            ctl,
   input  logic signed [rmjsl_pkg::POS_W-1:0] tgt_data,
   input  logic signed [rmjsl_pkg::POS_W-1:0] meas,
   input  logic [rmjsl_pkg::PROD_W-1:0]       prod,
   output logic signed [rmjsl_pkg::POS_W-1:0] cmd
);

   localparam int POS_W  = rmjsl_pkg::POS_W;
   localparam int SUM_W  = rmjsl_pkg::SPD_W + 2;
   localparam int STEP_W = rmjsl_pkg::PROD_W - rmjsl_pkg::FRAC_W;

   logic signed [POS_W-1:0] tgt_ff;
   logic signed [POS_W:0]   dev_ff, dev_in;
   logic [POS_W:0]          mag_ff, mag_in;
   logic                    near;
   logic [STEP_W-1:0]       step;
   logic [SUM_W-1:0]        meas_x, step_x, cmd_wide;

   // target state
   always_ff @(posedge clock) begin
      if (reset) begin
         tgt_ff <= '0;
      end else if (ctl.load_tgt) begin
         tgt_ff <= tgt_data;
      end
   end

   // deviation and its magnitude
   always_comb begin
      dev_in = {tgt_ff[POS_W-1], tgt_ff} - {meas[POS_W-1], meas};
      mag_in = dev_in[POS_W] ? (~dev_in + {{POS_W{1'b0}}, 1'b1}) : dev_in;
   end

   always_ff @(posedge clock) begin
      if (ctl.dev_en) begin
         dev_ff <= dev_in;
         mag_ff <= mag_in;
      end
   end

   // exact distance test and truncated step
   always_comb begin
      near   = {{(rmjsl_pkg::PROD_W-POS_W-1-rmjsl_pkg::FRAC_W){1'b0}}, mag_ff,
                {rmjsl_pkg::FRAC_W{1'b0}}} < prod;
      step   = prod[rmjsl_pkg::PROD_W-1:rmjsl_pkg::FRAC_W];
      meas_x = {{(SUM_W-POS_W){meas[POS_W-1]}}, meas};
      step_x = {{(SUM_W-STEP_W){1'b0}}, step};
      if (dev_ff[POS_W]) begin
         cmd_wide = meas_x - step_x;
      end else if (dev_ff != '0) begin
         cmd_wide = meas_x + step_x;
      end else begin
         cmd_wide = meas_x;
      end
   end

   // pick target or saturated step result
   always_comb begin
      if (near) begin
         cmd = tgt_ff;
      end else if (cmd_wide[SUM_W-1:POS_W-1] == '0
                   || cmd_wide[SUM_W-1:POS_W-1] == '1) begin
         cmd = cmd_wide[POS_W-1:0];
      end else if (cmd_wide[SUM_W-1]) begin
         cmd = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
         cmd = {1'b0, {(POS_W-1){1'b1}}};
      end
   end

endmodule

// ===== rtl/ramped_multi_joint_slew_limiter.sv =====
// Top level of the ramped multi-joint slew limiter: handshakes, sequencer,
// parallel joint lanes and the merged result register.
// Depends on rmjsl_pkg, rmjsl_speed and rmjsl_lane.
//
//   channel  dir  handshake           payload
//   req_     in   tvalid/tready       tuser = op, tdata = dt_us, pos_0..
//   rsp_     out  tvalid/tready       tdata = cmd_0..
//   csr_     in   valid/ready         index, data (max_speed, ramp_rate)
//
// A start or load item writes the lane targets; the sequencer stays idle.
// A tick goes from acceptance to the result register through ramp product,
// speed add and clip, step product with lane deviation, and lane command;
// no new item is taken until its result is registered. Both 32x16 products
// of the speed unit have stages of their own. Reset clears speed, targets,
// CSRs, state and rsp_tvalid. A waiting result stalls only a later tick in
// its last stage; loads and early tick stages run while rsp_tready is low.
module ramped_multi_joint_slew_limiter #(
   parameter int JOINTS = rmjsl_pkg::JOINTS_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   input  logic [rmjsl_pkg::OP_W-1:0]                 req_tuser, // op
   input  logic [rmjsl_pkg::DT_W+JOINTS*rmjsl_pkg::POS_W-1:0] req_tdata,
                                                      // dt_us, pos_0 .. pos_N
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   output logic [JOINTS*rmjsl_pkg::POS_W-1:0]         rsp_tdata, // cmd_0 .. cmd_N
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [rmjsl_pkg::CSR_IDX_W-1:0]            csr_index,
   input  logic [rmjsl_pkg::SPD_W-1:0]                csr_data
);

   localparam int POS_W  = rmjsl_pkg::POS_W;
   localparam int DT_W   = rmjsl_pkg::DT_W;
   localparam int VEC_W  = JOINTS * POS_W;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RAMP = 3'd1;
   localparam logic [2:0] ST_CLIP = 3'd2;
   localparam logic [2:0] ST_STEP = 3'd3;
   localparam logic [2:0] ST_CMD  = 3'd4;

   logic [2:0]                   state_ff, state_in;
   logic [rmjsl_pkg::SPD_W-1:0]  max_speed_ff, ramp_rate_ff;
   logic [DT_W-1:0]              dt_ff;
   logic [VEC_W-1:0]             meas_ff;
   logic                         rsp_valid_ff;
   logic [VEC_W-1:0]             rsp_data_ff;
   logic                         req_fire, load_fire, tick_fire, out_load;
   rmjsl_pkg::spd_ctl_type       spd_ctl;
   rmjsl_pkg::lane_ctl_type      lane_ctl;
   logic [rmjsl_pkg::PROD_W-1:0] prod;
   logic [VEC_W-1:0]             cmd_vec;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign req_fire   = req_tvalid && req_tready;
   assign load_fire  = req_fire && (req_tuser == rmjsl_pkg::OP_START
                                    || req_tuser == rmjsl_pkg::OP_LOAD);
   assign tick_fire  = req_fire && (req_tuser == rmjsl_pkg::OP_TICK);
   assign out_load   = (state_ff == ST_CMD) && (!rsp_valid_ff || rsp_tready);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_speed_ff <= '0;
         ramp_rate_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rmjsl_pkg::CSR_MAX_SPEED: max_speed_ff <= csr_data;
            rmjsl_pkg::CSR_RAMP_RATE: ramp_rate_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // tick sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (tick_fire) state_in = ST_RAMP;
         ST_RAMP: state_in = ST_CLIP;
         ST_CLIP: state_in = ST_STEP;
         ST_STEP: state_in = ST_CMD;
         ST_CMD:  if (out_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // tick payload
   always_ff @(posedge clock) begin
      if (tick_fire) begin
         dt_ff   <= req_tdata[DT_W-1:0];
         meas_ff <= req_tdata[DT_W +: VEC_W];
      end
   end

   assign spd_ctl.ramp_en  = (state_ff == ST_RAMP);
   assign spd_ctl.clip_en  = (state_ff == ST_CLIP);
   assign spd_ctl.step_en  = (state_ff == ST_STEP);
   assign lane_ctl.load_tgt = load_fire;
   assign lane_ctl.dev_en   = (state_ff == ST_STEP);

   rmjsl_speed u_speed (
      .clock     (clock),
      .reset     (reset),
      .ctl       (spd_ctl),
      .max_speed (max_speed_ff),
      .ramp_rate (ramp_rate_ff),
      .dt_us     (dt_ff),
      .prod      (prod)
   );

   // one lane per joint
   for (genvar j = 0; j < JOINTS; j++) begin : g_lane
      rmjsl_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctl      (lane_ctl),
         .tgt_data (req_tdata[DT_W + j*POS_W +: POS_W]),
         .meas     (meas_ff[j*POS_W +: POS_W]),
         .prod     (prod),
         .cmd      (cmd_vec[j*POS_W +: POS_W])
      );
   end

   // merged result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= cmd_vec;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
